### rtl/psr_pkg.sv
// Shared types and constants for the predictive stack recognizer.
package psr_pkg;

  localparam logic [2:0] KIND_HEAD  = 3'd0;
  localparam logic [2:0] KIND_BODY  = 3'd1;
  localparam logic [2:0] KIND_START = 3'd2;
  localparam logic [2:0] KIND_CHAR  = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  localparam logic [1:0] STAT_FINE     = 2'd0;
  localparam logic [1:0] STAT_REJECTED = 2'd1;
  localparam logic [1:0] STAT_ACCEPTED = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  localparam logic [7:0] END_MARK = 8'h24;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] rule_index;
    logic [2:0] symbol_pos;
    logic [7:0] symbol;
    logic [3:0] rule_length;
  } in_word_t;

endpackage

### rtl/psr_rule_mem.sv
// Grammar table storage: rule heads, lengths and right-side symbols.
module psr_rule_mem #(
  parameter int MAX_RULES = 16,
  parameter int MAX_RHS   = 8,
  parameter int RIW       = 4,
  parameter int BAW       = 7
) (
  input  logic           clk_i,
  input  logic           head_we_i,
  input  logic [RIW-1:0] head_waddr_i,
  input  logic [7:0]     head_wdata_i,
  input  logic [3:0]     len_wdata_i,
  input  logic [RIW-1:0] head_raddr_i,
  output logic [7:0]     head_rdata_o,
  output logic [3:0]     len_rdata_o,
  input  logic           body_we_i,
  input  logic [BAW-1:0] body_waddr_i,
  input  logic [7:0]     body_wdata_i,
  input  logic [BAW-1:0] body_raddr_i,
  output logic [7:0]     body_rdata_o
);

  logic [7:0] heads_mem  [MAX_RULES];
  logic [3:0] lens_mem   [MAX_RULES];
  logic [7:0] bodies_mem [MAX_RULES*MAX_RHS];

  always_ff @(posedge clk_i) begin
    if (head_we_i) begin
      heads_mem[head_waddr_i] <= head_wdata_i;
      lens_mem[head_waddr_i]  <= len_wdata_i;
    end
    head_rdata_o <= heads_mem[head_raddr_i];
    len_rdata_o  <= lens_mem[head_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (body_we_i) begin
      bodies_mem[body_waddr_i] <= body_wdata_i;
    end
    body_rdata_o <= bodies_mem[body_raddr_i];
  end

endmodule

### rtl/psr_stack_mem.sv
// Symbol stack memory with a flag tracking the bottom entry.
module psr_stack_mem #(
  parameter int STACK_DEPTH = 64,
  parameter int SAW         = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  logic [SAW-1:0] waddr_i,
  input  logic [7:0]     wdata_i,
  input  logic [SAW-1:0] raddr_i,
  output logic [7:0]     rdata_o,
  output logic           bottom_end_o
);

  logic [7:0] stack_mem [STACK_DEPTH];
  logic       bottom_end_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stack_mem[waddr_i] <= wdata_i;
    end
    rdata_o <= stack_mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_end_q <= 1'b0;
    end else if (we_i && waddr_i == '0) begin
      bottom_end_q <= (wdata_i == psr_pkg::END_MARK);
    end
  end

  assign bottom_end_o = bottom_end_q;

endmodule

### rtl/psr_ctrl.sv
// Sequencer: rule search, stack expansion and result register.
module psr_ctrl #(
  parameter int MAX_RULES   = 16,
  parameter int MAX_RHS     = 8,
  parameter int STACK_DEPTH = 64,
  parameter int RIW         = 4,
  parameter int BAW         = 7,
  parameter int SAW         = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  psr_pkg::in_word_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [6:0]       stack_depth_o,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_wdata_i,
  output logic             head_we_o,
  output logic [RIW-1:0]   head_waddr_o,
  output logic [RIW-1:0]   head_raddr_o,
  input  logic [7:0]       head_rdata_i,
  input  logic [3:0]       len_rdata_i,
  output logic             body_we_o,
  output logic [BAW-1:0]   body_waddr_o,
  output logic [BAW-1:0]   body_raddr_o,
  input  logic [7:0]       body_rdata_i,
  output logic             stk_we_o,
  output logic [SAW-1:0]   stk_waddr_o,
  output logic [7:0]       stk_wdata_o,
  output logic [SAW-1:0]   stk_raddr_o,
  input  logic [7:0]       stk_rdata_i,
  input  logic             bottom_end_i
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(MAX_RULES + 1);
  localparam int RCW = (CW > 5) ? CW : 5;
  localparam int NW  = ($clog2(MAX_RHS + 1) > 4) ? $clog2(MAX_RHS + 1) : 4;
  localparam int OW  = ((SPW > NW) ? SPW : NW) + 1;
  localparam int XW  = (SPW > 7) ? SPW : 7;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_START    = 3'd1;
  localparam logic [2:0] S_TOP      = 3'd2;
  localparam logic [2:0] S_RULE_RD  = 3'd3;
  localparam logic [2:0] S_RULE_CMP = 3'd4;
  localparam logic [2:0] S_PUSH_RD  = 3'd5;
  localparam logic [2:0] S_PUSH_WR  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]     state_q, state_d;
  logic [2:0]     kind_q, kind_d;
  logic [7:0]     sym_q, sym_d;
  logic [7:0]     top_q, top_d;
  logic [RCW-1:0] r_q, r_d;
  logic [NW-1:0]  j_q, j_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [1:0]     failed_q, failed_d;
  logic [4:0]     rule_count_q;
  logic           out_valid_q, out_valid_d;
  logic [1:0]     status_q, status_d;
  logic [6:0]     depth_q, depth_d;

  logic           accept;
  logic [NW-1:0]  len_ext, eff_len;
  logic [RCW-1:0] limit, r_next;
  logic           hit, ovf;
  logic [SPW-1:0] sp_m1;
  logic [XW-1:0]  sp_x;
  logic [1:0]     status_now;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign len_ext = NW'(len_rdata_i);
  assign eff_len = (len_ext > NW'(MAX_RHS)) ? NW'(MAX_RHS) : len_ext;
  assign limit   = (RCW'(rule_count_q) > RCW'(MAX_RULES)) ? RCW'(MAX_RULES)
                                                           : RCW'(rule_count_q);
  assign r_next  = r_q + RCW'(1);
  assign hit     = (eff_len != '0) && (head_rdata_i == top_q) && (body_rdata_i == sym_q);
  // a net depth below zero also counts as overflow
  assign ovf     = ((OW'(sp_q) + OW'(eff_len)) > (OW'(STACK_DEPTH) + OW'(2))) ||
                   ((OW'(sp_q) + OW'(eff_len)) < OW'(2));
  assign sp_m1   = sp_q - SPW'(1);
  assign sp_x    = XW'(sp_q);

  // table writes happen in the accept cycle
  assign head_we_o    = accept && (in_word_i.kind == psr_pkg::KIND_HEAD) &&
                        (int'(in_word_i.rule_index) < MAX_RULES);
  assign head_waddr_o = RIW'(in_word_i.rule_index);
  assign body_we_o    = accept && (in_word_i.kind == psr_pkg::KIND_BODY) &&
                        (int'(in_word_i.rule_index) < MAX_RULES) &&
                        (int'(in_word_i.symbol_pos) < MAX_RHS);
  assign body_waddr_o = BAW'(int'(in_word_i.rule_index) * MAX_RHS +
                             int'(in_word_i.symbol_pos));

  assign head_raddr_o = (state_q == S_IDLE) ? '0 : r_q[RIW-1:0];
  assign body_raddr_o = BAW'(int'(r_q) * MAX_RHS +
                             ((state_q == S_PUSH_RD) ? int'(j_q) : 0));
  assign stk_raddr_o  = sp_m1[SAW-1:0];

  always_comb begin
    stk_we_o    = 1'b0;
    stk_waddr_o = '0;
    stk_wdata_o = psr_pkg::END_MARK;
    case (state_q)
      S_IDLE: begin
        stk_we_o = accept && (in_word_i.kind == psr_pkg::KIND_START);
      end
      S_START: begin
        stk_we_o    = 1'b1;
        stk_waddr_o = SAW'(1);
        stk_wdata_o = head_rdata_i;
      end
      S_PUSH_WR: begin
        stk_we_o    = 1'b1;
        stk_waddr_o = sp_q[SAW-1:0];
        stk_wdata_o = body_rdata_i;
      end
      default: begin
        stk_we_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    status_now = failed_q;
    if (kind_q == psr_pkg::KIND_END && failed_q == psr_pkg::STAT_FINE) begin
      status_now = (sp_q == SPW'(1) && bottom_end_i) ? psr_pkg::STAT_ACCEPTED
                                                     : psr_pkg::STAT_REJECTED;
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    sym_d       = sym_q;
    top_d       = top_q;
    r_d         = r_q;
    j_d         = j_q;
    sp_d        = sp_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    depth_d     = depth_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = in_word_i.kind;
          sym_d   = in_word_i.symbol;
          state_d = S_DONE;
          if (in_word_i.kind == psr_pkg::KIND_START) begin
            state_d = S_START;
          end else if (in_word_i.kind == psr_pkg::KIND_CHAR &&
                       failed_q == psr_pkg::STAT_FINE && sp_q != '0) begin
            state_d = S_TOP;
          end
        end
      end
      S_START: begin
        sp_d     = SPW'(2);
        failed_d = psr_pkg::STAT_FINE;
        state_d  = S_DONE;
      end
      S_TOP: begin
        top_d = stk_rdata_i;
        r_d   = '0;
        if (stk_rdata_i == sym_q) begin
          sp_d    = sp_m1;
          state_d = S_DONE;
        end else if (limit == '0) begin
          failed_d = psr_pkg::STAT_REJECTED;
          state_d  = S_DONE;
        end else begin
          state_d = S_RULE_RD;
        end
      end
      S_RULE_RD: begin
        state_d = S_RULE_CMP;
      end
      S_RULE_CMP: begin
        if (hit) begin
          if (ovf) begin
            failed_d = psr_pkg::STAT_OVERFLOW;
            state_d  = S_DONE;
          end else begin
            sp_d    = sp_m1;
            j_d     = eff_len - NW'(1);
            state_d = (eff_len == NW'(1)) ? S_DONE : S_PUSH_RD;
          end
        end else if (r_next >= limit) begin
          failed_d = psr_pkg::STAT_REJECTED;
          state_d  = S_DONE;
        end else begin
          r_d     = r_next;
          state_d = S_RULE_RD;
        end
      end
      S_PUSH_RD: begin
        state_d = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        sp_d    = sp_q + SPW'(1);
        j_d     = j_q - NW'(1);
        state_d = (j_q == NW'(1)) ? S_DONE : S_PUSH_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = status_now;
          depth_d     = sp_x[6:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sp_q         <= '0;
      failed_q     <= psr_pkg::STAT_FINE;
      rule_count_q <= 5'd1;
      out_valid_q  <= 1'b0;
      r_q          <= '0;
      j_q          <= '0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
      r_q         <= r_d;
      j_q         <= j_d;
      if (cfg_we_i) begin
        rule_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    sym_q    <= sym_d;
    top_q    <= top_d;
    status_q <= status_d;
    depth_q  <= depth_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign stack_depth_o = depth_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OW'(sp_q) <= OW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_failed_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q != psr_pkg::STAT_ACCEPTED)
    else $error("accepted code held in failure flag");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted word left no work");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside done state");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH_WR |-> OW'(sp_q) < OW'(STACK_DEPTH))
    else $error("push past top of stack");

endmodule

### rtl/predictive_stack_recognizer.sv
// Steps: load, end and ignored words go straight to the result; a start word writes the end
// mark and start symbol; a character reads the stack top, matches it or searches the rules.
// Throughput: one word at a time, stretched while a held result is stalled; the rule search
// and stack pushes share the one registered body read port of the rule table.
// Reset: stack empty, failure flag clear, rule_count 1; tables hold garbage until loaded.
// Top level of the predictive stack recognizer.
module predictive_stack_recognizer #(
  parameter int MAX_RULES   = 16,
  parameter int MAX_RHS     = 8,
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [3:0] rule_index_i,
  input  logic [2:0] symbol_pos_i,
  input  logic [7:0] symbol_i,
  input  logic [3:0] rule_length_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [6:0] stack_depth_o,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);

  localparam int RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int BAW = (MAX_RULES * MAX_RHS > 1) ? $clog2(MAX_RULES * MAX_RHS) : 1;
  localparam int SAW = $clog2(STACK_DEPTH);

  psr_pkg::in_word_t in_word;

  logic           head_we, body_we, stk_we, bottom_end;
  logic [RIW-1:0] head_waddr, head_raddr;
  logic [7:0]     head_rdata, body_rdata, stk_wdata, stk_rdata;
  logic [3:0]     len_rdata;
  logic [BAW-1:0] body_waddr, body_raddr;
  logic [SAW-1:0] stk_waddr, stk_raddr;

  assign in_word.kind        = kind_i;
  assign in_word.rule_index  = rule_index_i;
  assign in_word.symbol_pos  = symbol_pos_i;
  assign in_word.symbol      = symbol_i;
  assign in_word.rule_length = rule_length_i;

  psr_rule_mem #(
    .MAX_RULES(MAX_RULES),
    .MAX_RHS  (MAX_RHS),
    .RIW      (RIW),
    .BAW      (BAW)
  ) u_rule_mem (
    .clk_i       (clk_i),
    .head_we_i   (head_we),
    .head_waddr_i(head_waddr),
    .head_wdata_i(symbol_i),
    .len_wdata_i (rule_length_i),
    .head_raddr_i(head_raddr),
    .head_rdata_o(head_rdata),
    .len_rdata_o (len_rdata),
    .body_we_i   (body_we),
    .body_waddr_i(body_waddr),
    .body_wdata_i(symbol_i),
    .body_raddr_i(body_raddr),
    .body_rdata_o(body_rdata)
  );

  psr_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .SAW        (SAW)
  ) u_stack_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (stk_we),
    .waddr_i     (stk_waddr),
    .wdata_i     (stk_wdata),
    .raddr_i     (stk_raddr),
    .rdata_o     (stk_rdata),
    .bottom_end_o(bottom_end)
  );

  psr_ctrl #(
    .MAX_RULES  (MAX_RULES),
    .MAX_RHS    (MAX_RHS),
    .STACK_DEPTH(STACK_DEPTH),
    .RIW        (RIW),
    .BAW        (BAW),
    .SAW        (SAW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .stack_depth_o(stack_depth_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_we_o    (head_we),
    .head_waddr_o (head_waddr),
    .head_raddr_o (head_raddr),
    .head_rdata_i (head_rdata),
    .len_rdata_i  (len_rdata),
    .body_we_o    (body_we),
    .body_waddr_o (body_waddr),
    .body_raddr_o (body_raddr),
    .body_rdata_i (body_rdata),
    .stk_we_o     (stk_we),
    .stk_waddr_o  (stk_waddr),
    .stk_wdata_o  (stk_wdata),
    .stk_raddr_o  (stk_raddr),
    .stk_rdata_i  (stk_rdata),
    .bottom_end_i (bottom_end)
  );

endmodule
